FILE: design/dem3_pkg.sv
// shared types, character codes and helper functions for the decimal entry median block
package dem3_pkg;

   localparam int MAX_CHARS    = 15;
   localparam int CHAR_COUNT_W = $clog2(MAX_CHARS + 1);
   localparam logic [CHAR_COUNT_W-1:0] MAX_CHARS_C = CHAR_COUNT_W'(MAX_CHARS);

   localparam int DATA_W     = 32;
   localparam int HIST_DEPTH = 3;
   localparam int PTR_W      = $clog2(HIST_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HIST_DEPTH - 1);

   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_END   = 8'h65;
   localparam logic [7:0] CHAR_CLEAR = 8'h46;

   typedef logic signed [DATA_W-1:0] value_type;

   typedef struct packed {
      logic is_digit;
      logic is_minus;
      logic is_end;
      logic is_clear;
   } char_class_type;

   typedef struct packed {
      logic write;
      logic clear;
   } hist_cmd_type;

   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type cls;
      cls.is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      cls.is_minus = (ch == CHAR_MINUS);
      cls.is_end   = (ch == CHAR_END);
      cls.is_clear = (ch == CHAR_CLEAR);
      return cls;
   endfunction

   function automatic value_type mid_of_three(input value_type a, input value_type b,
                                              input value_type c);
      value_type mid;
      if (a < b) begin
         if (b < c)      mid = b;
         else if (a < c) mid = c;
         else            mid = a;
      end else begin
         if (a < c)      mid = a;
         else if (b < c) mid = c;
         else            mid = b;
      end
      return mid;
   endfunction

endpackage

FILE: design/dem3_parser.sv
// running atoi-style parse of the entered characters
module dem3_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              char_code,
   input  dem3_pkg::char_class_type cls,
   output dem3_pkg::value_type     value
);

   logic [dem3_pkg::DATA_W-1:0]       acc_ff, acc_in;
   logic                              neg_ff, neg_in;
   logic                              stop_ff, stop_in;
   logic [dem3_pkg::CHAR_COUNT_W-1:0] count_ff, count_in;
   logic [7:0]                        digit_raw;
   logic [dem3_pkg::DATA_W-1:0]       digit;

   assign digit_raw = char_code - dem3_pkg::CHAR_ZERO;
   assign digit     = dem3_pkg::DATA_W'(digit_raw[3:0]);
   assign value     = neg_ff ? dem3_pkg::value_type'(-acc_ff) : dem3_pkg::value_type'(acc_ff);

   always_comb begin
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      stop_in  = stop_ff;
      count_in = count_ff;
      if (step) begin
         if ((cls.is_digit || cls.is_minus) && (count_ff < dem3_pkg::MAX_CHARS_C)) begin
            if (cls.is_minus) begin
               if (count_ff == '0) neg_in  = 1'b1;
               else                stop_in = 1'b1;
            end else if (!stop_ff) begin
               // times ten as two shifts
               acc_in = (acc_ff << 3) + (acc_ff << 1) + digit;
            end
            count_in = count_ff + 1'b1;
         end else if (cls.is_end) begin
            acc_in   = '0;
            neg_in   = 1'b0;
            stop_in  = 1'b0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         stop_ff  <= stop_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/dem3_history.sv
// three-entry ring of parsed values with wrapping sum and median
module dem3_history (
   input  logic                   clock,
   input  logic                   reset,
   input  dem3_pkg::hist_cmd_type cmd,
   input  dem3_pkg::value_type    value,
   output dem3_pkg::value_type    sum,
   output dem3_pkg::value_type    median
);

   dem3_pkg::value_type          hist_ff [dem3_pkg::HIST_DEPTH];
   dem3_pkg::value_type          hist_in [dem3_pkg::HIST_DEPTH];
   logic [dem3_pkg::PTR_W-1:0]   ptr_ff, ptr_in, ptr_next;
   logic                         full_ff, full_in, full_next;
   logic signed [dem3_pkg::DATA_W:0] pair;
   logic signed [dem3_pkg::DATA_W:0] pair_adj;

   // ring contents as they stand after this write, used for the outputs
   always_comb begin
      for (int i = 0; i < dem3_pkg::HIST_DEPTH; i++) begin
         hist_in[i] = (ptr_ff == dem3_pkg::PTR_W'(i)) ? value : hist_ff[i];
      end
      ptr_next  = (ptr_ff == dem3_pkg::PTR_LAST) ? '0 : ptr_ff + 1'b1;
      full_next = full_ff || (ptr_ff == dem3_pkg::PTR_LAST);
   end

   assign sum = hist_in[0] + hist_in[1] + hist_in[2];

   // truncate toward zero: bump odd negatives before the arithmetic shift
   assign pair     = {hist_in[0][dem3_pkg::DATA_W-1], hist_in[0]}
                   + {hist_in[1][dem3_pkg::DATA_W-1], hist_in[1]};
   assign pair_adj = pair + {{dem3_pkg::DATA_W{1'b0}}, pair[dem3_pkg::DATA_W] & pair[0]};

   always_comb begin
      if (full_next)
         median = dem3_pkg::mid_of_three(hist_in[0], hist_in[1], hist_in[2]);
      else if (ptr_next == dem3_pkg::PTR_W'(1))
         median = hist_in[0];
      else
         median = dem3_pkg::value_type'(pair_adj >>> 1);
   end

   always_comb begin
      ptr_in  = ptr_ff;
      full_in = full_ff;
      if (cmd.clear) begin
         ptr_in  = '0;
         full_in = 1'b0;
      end else if (cmd.write) begin
         ptr_in  = ptr_next;
         full_in = full_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < dem3_pkg::HIST_DEPTH; i++) hist_ff[i] <= '0;
      end else if (cmd.write) begin
         for (int i = 0; i < dem3_pkg::HIST_DEPTH; i++) hist_ff[i] <= hist_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         full_ff <= full_in;
      end
   end

endmodule

FILE: design/decimal_entry_median_of_three.sv
// decimal entry top level: input register, parse and ring update, result register
// the 'e' character waits in the input register; the result register loads when it advances
// throughput: one character per cycle while no held result stalls an end character
// a held result stalls only characters that produce a result, others keep flowing
// reset (synchronous): parser state, ring, pointer and both channels are cleared
module decimal_entry_median_of_three (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_typed_value,
   output logic signed [31:0]  rsp_history_sum,
   output logic signed [31:0]  rsp_median_value
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_char_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   dem3_pkg::value_type      typed_ff, sum_ff, median_ff;
   dem3_pkg::char_class_type cls;
   dem3_pkg::hist_cmd_type   hist_cmd;
   dem3_pkg::value_type      value, sum, median;
   logic                     advance;
   logic                     load;

   assign cls     = dem3_pkg::classify(in_char_ff);
   assign advance = in_valid_ff && (!cls.is_end || !rsp_valid_ff || rsp_ready);
   assign load    = advance && cls.is_end;

   assign req_ready = !in_valid_ff || advance;

   assign hist_cmd.write = load;
   assign hist_cmd.clear = advance && cls.is_clear;

   dem3_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .cls       (cls),
      .value     (value)
   );

   dem3_history u_history (
      .clock  (clock),
      .reset  (reset),
      .cmd    (hist_cmd),
      .value  (value),
      .sum    (sum),
      .median (median)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_char_ff <= req_char_code;
      if (load) begin
         typed_ff  <= value;
         sum_ff    <= sum;
         median_ff <= median;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_typed_value  = typed_ff;
   assign rsp_history_sum  = sum_ff;
   assign rsp_median_value = median_ff;

   // a loaded result is always offered in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("result load did not raise rsp_valid");

   // a result still waiting is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !load)
      else $error("held result overwritten");

   // an empty input register always takes a transaction
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   // a transaction that is not an end character never creates a result
   a_only_end: assert property (@(posedge clock) disable iff (reset)
      (advance && !cls.is_end && !rsp_valid) |=> !rsp_valid)
      else $error("result without end character");

endmodule
